// ===== design/cfs_pkg.sv =====
package cfs_pkg;

   localparam int CHANNELS_DEFAULT = 6;
   localparam int FIELD_W          = 6;
   localparam int STATUS_W         = 2 * FIELD_W;
   localparam int TIME_W           = 32;
   localparam int REQ_DATA_W       = 56;
   localparam int RSP_DATA_W       = 32;

   localparam logic [TIME_W-1:0] ACTION_GAP_RESET = TIME_W'(50);

   typedef enum logic [1:0] {
      STATUS_NO_CON  = 2'd0,
      STATUS_CONNECT = 2'd1,
      STATUS_FIRED   = 2'd2
   } status_code_type;

   // visible state of the fire step, after the item is applied
   typedef struct packed {
      logic [FIELD_W-1:0] drive;
      logic [FIELD_W-1:0] fired;
      logic               busy;
   } fire_view_type;

endpackage

// ===== design/channel_fire_sequencer.sv =====
// Channel fire sequencer: steps a firing sequence over up to six channels and
// reports a two-bit status per channel. Each req transfer carries a timestamp,
// a start request, the channel mask and the sensed control and detect pins;
// each one yields exactly one rsp transfer with the drive outputs, the status
// codes, the busy flag and the latched fired flags, all taken after the item
// is applied. An accepted item is held in the input register, where a
// 32-bit elapsed-time subtract and compare plus a priority pick of the next
// masked channel produce the new state, which is loaded together with the
// result register; a new item is taken every cycle as long as the rsp side
// keeps up. The delay register (reset 50) is written through
// csr_wr_en/csr_wr_data; the user must write it only while no item is in
// flight, as the block does not enforce it. Fired flags clear only at reset.
module channel_fire_sequencer
   import cfs_pkg::*;
#(
   parameter int CHANNELS = CHANNELS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   // configuration
   input  logic                  csr_wr_en,
   input  logic [TIME_W-1:0]     csr_wr_data,
   // item input
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // time_now[31:0], fire_start[32], channel_mask[38:33], ctl_sense[44:39],
   // det_sense[50:45], zero fill [55:51]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // result output
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // drive_enable[5:0], channel_status[17:6], fire_busy[18],
   // fired_mask[24:19], zero fill [31:25]
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   // minimum gap between firing actions
   logic [TIME_W-1:0] action_gap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         action_gap_ff <= ACTION_GAP_RESET;
      end else if (csr_wr_en) begin
         action_gap_ff <= csr_wr_data;
      end
   end

   // input register
   logic                  in_valid_ff;
   logic [REQ_DATA_W-1:0] in_data_ff;
   logic                  advance;

   // the result register frees up when empty or when its transfer completes
   assign advance    = in_valid_ff && (!rsp_tvalid || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_data_ff <= req_tdata;
      end
   end

   // unpack the held item
   logic [TIME_W-1:0]  time_now;
   logic               fire_start;
   logic [FIELD_W-1:0] channel_mask;
   logic [FIELD_W-1:0] ctl_sense;
   logic [FIELD_W-1:0] det_sense;

   assign time_now     = in_data_ff[31:0];
   assign fire_start   = in_data_ff[32];
   assign channel_mask = in_data_ff[38:33];
   assign ctl_sense    = in_data_ff[44:39];
   assign det_sense    = in_data_ff[50:45];

   // fire step, state moves only when the item is passed on
   fire_view_type view;

   cfs_fire_step #(
      .CHANNELS(CHANNELS)
   ) u_fire (
      .clock        (clock),
      .reset        (reset),
      .step_en      (advance),
      .time_now     (time_now),
      .fire_start   (fire_start),
      .channel_mask (channel_mask),
      .action_gap   (action_gap_ff),
      .view         (view)
   );

   // detect step, uses the fired flags after the fire step
   logic [STATUS_W-1:0] channel_status;

   cfs_status #(
      .CHANNELS(CHANNELS)
   ) u_status (
      .ctl_sense      (ctl_sense),
      .det_sense      (det_sense),
      .fired          (view.fired),
      .channel_status (channel_status)
   );

   // result register
   logic                  out_valid_ff;
   logic [RSP_DATA_W-1:0] out_data_ff;
   logic [RSP_DATA_W-1:0] out_data_in;

   assign out_data_in = {7'd0, view.fired, view.busy, channel_status, view.drive};

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

// ===== design/cfs_fire_step.sv =====
module cfs_fire_step
   import cfs_pkg::*;
#(
   parameter int CHANNELS = CHANNELS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                step_en,
   input  logic [TIME_W-1:0]   time_now,
   input  logic                fire_start,
   input  logic [FIELD_W-1:0]  channel_mask,
   input  logic [TIME_W-1:0]   action_gap,
   output fire_view_type       view
);

   localparam int STEP_W = $clog2(CHANNELS + 1);

   logic [TIME_W-1:0]   last_time_ff, last_time_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic                pending_ff, pending_in;
   logic [CHANNELS-1:0] drive_ff, drive_in;
   logic [CHANNELS-1:0] fired_ff, fired_in;

   logic [CHANNELS-1:0] mask_ext;
   logic [CHANNELS-1:0] pick_vec;
   logic [STEP_W-1:0]   pick_step;
   logic                found;
   logic                pending_now;
   logic [TIME_W-1:0]   elapsed;
   logic                act;

   // mask bits beyond the field are zero
   for (genvar g = 0; g < CHANNELS; g++) begin : g_mask
      if (g < FIELD_W) begin : g_in
         assign mask_ext[g] = channel_mask[g];
      end else begin : g_zero
         assign mask_ext[g] = 1'b0;
      end
   end

   // lowest masked channel at or after the current step
   always_comb begin
      found     = 1'b0;
      pick_vec  = '0;
      pick_step = '0;
      for (int i = 0; i < CHANNELS; i++) begin
         if (!found && mask_ext[i] && (STEP_W'(i) >= step_ff)) begin
            found       = 1'b1;
            pick_vec[i] = 1'b1;
            pick_step   = STEP_W'(i + 1);
         end
      end
   end

   assign pending_now = pending_ff | fire_start;
   assign elapsed     = time_now - last_time_ff;
   assign act         = pending_now && (elapsed >= action_gap);

   always_comb begin
      last_time_in = last_time_ff;
      step_in      = step_ff;
      pending_in   = pending_now;
      drive_in     = drive_ff;
      fired_in     = fired_ff;
      if (act) begin
         last_time_in = time_now;
         if (found) begin
            drive_in = drive_ff | pick_vec;
            fired_in = fired_ff | pick_vec;
            step_in  = pick_step;
         end else begin
            drive_in   = '0;
            pending_in = 1'b0;
            step_in    = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_time_ff <= '0;
         step_ff      <= '0;
         pending_ff   <= 1'b0;
         drive_ff     <= '0;
         fired_ff     <= '0;
      end else if (step_en) begin
         last_time_ff <= last_time_in;
         step_ff      <= step_in;
         pending_ff   <= pending_in;
         drive_ff     <= drive_in;
         fired_ff     <= fired_in;
      end
   end

   for (genvar g = 0; g < FIELD_W; g++) begin : g_view
      if (g < CHANNELS) begin : g_on
         assign view.drive[g] = drive_in[g];
         assign view.fired[g] = fired_in[g];
      end else begin : g_off
         assign view.drive[g] = 1'b0;
         assign view.fired[g] = 1'b0;
      end
   end
   assign view.busy = pending_in;

endmodule

// ===== design/cfs_status.sv =====
module cfs_status
   import cfs_pkg::*;
#(
   parameter int CHANNELS = CHANNELS_DEFAULT
) (
   input  logic [FIELD_W-1:0]  ctl_sense,
   input  logic [FIELD_W-1:0]  det_sense,
   input  logic [FIELD_W-1:0]  fired,
   output logic [STATUS_W-1:0] channel_status
);

   for (genvar g = 0; g < FIELD_W; g++) begin : g_chan
      if (g < CHANNELS) begin : g_on
         status_code_type code;
         always_comb begin
            if (ctl_sense[g] || fired[g]) begin
               code = STATUS_FIRED;
            end else if (det_sense[g]) begin
               code = STATUS_CONNECT;
            end else begin
               code = STATUS_NO_CON;
            end
         end
         assign channel_status[2*g +: 2] = code;
      end else begin : g_off
         assign channel_status[2*g +: 2] = STATUS_NO_CON;
      end
   end

endmodule

// ===== sim/tb_top.sv =====
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import cfs_pkg::*;

   localparam int NUM_CHANNELS   = CHANNELS_DEFAULT;
   localparam int ITEMS_PER_RUN  = 206;    // random items per delay setting
   localparam int NUM_SETTINGS   = 8;
   localparam int LONG_HOLD      = 400;    // cycles the rsp side holds off once
   localparam int TAIL_CYCLES    = 8;      // margin for the pipeline to empty
   localparam int CYCLE_LIMIT    = 200000;
   localparam int NUM_ROWS       = 21;

   // one req transfer, fields listed in tdata order from bit 0 up
   typedef struct packed {
      logic [TIME_W-1:0]  time_now;
      logic               fire_start;
      logic [FIELD_W-1:0] channel_mask;
      logic [FIELD_W-1:0] ctl_sense;
      logic [FIELD_W-1:0] det_sense;
   } fire_item_type;

   // one rsp transfer
   typedef struct packed {
      logic [FIELD_W-1:0]  drive_enable;
      logic [STATUS_W-1:0] channel_status;
      logic                fire_busy;
      logic [FIELD_W-1:0]  fired_mask;
   } channel_report_type;

   // directed row: item, plus a hand-written report where one is given
   typedef struct packed {
      fire_item_type      item;
      logic               typed;
      channel_report_type want;
   } directed_row_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_wr_en;
   logic [TIME_W-1:0]     csr_wr_data;
   logic                  req_tvalid;
   logic                  req_tready;
   // time_now[31:0], fire_start[32], channel_mask[38:33], ctl_sense[44:39],
   // det_sense[50:45], zero fill [55:51]
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   // drive_enable[5:0], channel_status[17:6], fire_busy[18],
   // fired_mask[24:19], zero fill [31:25]
   logic [RSP_DATA_W-1:0] rsp_tdata;

   channel_fire_sequencer #(
      .CHANNELS (NUM_CHANNELS)
   ) u_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   always #1 clock = ~clock;

   // ------------------------------------------------------------------
   // sequencer model state, mirrors the block after each item
   // ------------------------------------------------------------------
   logic [TIME_W-1:0]  action_gap_q;
   logic [TIME_W-1:0]  last_fire_time;
   logic [2:0]         next_chan;
   logic               fire_armed;
   logic [FIELD_W-1:0] drive_state;
   logic [FIELD_W-1:0] fired_state;

   channel_report_type pending_reports[$];   // reports still owed by the block

   int err_count     = 0;
   int report_count  = 0;
   int items_sent    = 0;
   int settings_used = 1;
   int fire_actions  = 0;
   int seq_complete  = 0;
   int burst_left    = 0;
   int cycle_count   = 0;
   bit long_hold_req = 1'b0;

   // directed stimulus, run at the reset delay of 50
   directed_row_type directed_rows [NUM_ROWS] = '{
      // idle after reset: everything off
      '{'{32'h0000_0000, 1'b0, 6'h00, 6'h00, 6'h00}, 1'b1, '{6'h00, 12'h000, 1'b0, 6'h00}},
      // all detect pins: every channel connected
      '{'{32'h0000_0000, 1'b0, 6'h00, 6'h00, 6'h3f}, 1'b1, '{6'h00, 12'h555, 1'b0, 6'h00}},
      // all control pins: every channel reads fired
      '{'{32'h0000_0000, 1'b0, 6'h00, 6'h3f, 6'h00}, 1'b1, '{6'h00, 12'haaa, 1'b0, 6'h00}},
      // start too early for the delay, busy only
      '{'{32'd10,        1'b1, 6'h3f, 6'h00, 6'h15}, 1'b1, '{6'h00, 12'h111, 1'b1, 6'h00}},
      // delay reached exactly, channel 0 fires
      '{'{32'd50,        1'b0, 6'h3f, 6'h00, 6'h00}, 1'b1, '{6'h01, 12'h002, 1'b1, 6'h01}},
      // one tick short
      '{'{32'd99,        1'b0, 6'h3f, 6'h00, 6'h3f}, 1'b0, '0},
      // sparse mask skips ahead to channel 3, then 5, then ends
      '{'{32'd100,       1'b0, 6'h28, 6'h00, 6'h00}, 1'b0, '0},
      '{'{32'd150,       1'b0, 6'h28, 6'h3f, 6'h3f}, 1'b0, '0},
      '{'{32'd200,       1'b0, 6'h28, 6'h00, 6'h00}, 1'b0, '0},
      // new sequence with an empty mask ends on its first action, flags kept
      '{'{32'd200,       1'b1, 6'h00, 6'h00, 6'h00}, 1'b0, '0},
      '{'{32'd250,       1'b0, 6'h00, 6'h00, 6'h00}, 1'b0, '0},
      // elapsed time across the 2^32 wrap
      '{'{32'hffff_fff0, 1'b1, 6'h01, 6'h00, 6'h00}, 1'b0, '0},
      '{'{32'h0000_0022, 1'b0, 6'h02, 6'h00, 6'h00}, 1'b0, '0},
      '{'{32'h0000_0023, 1'b0, 6'h3f, 6'h00, 6'h00}, 1'b0, '0},
      '{'{32'h0000_0054, 1'b0, 6'h3f, 6'h01, 6'h3f}, 1'b0, '0},
      '{'{32'hffff_ffff, 1'b0, 6'h3f, 6'h2a, 6'h15}, 1'b0, '0},
      '{'{32'hffff_ffff, 1'b0, 6'h3f, 6'h00, 6'h00}, 1'b0, '0},
      '{'{32'h0000_0031, 1'b0, 6'h3f, 6'h00, 6'h00}, 1'b0, '0},
      '{'{32'h0000_0063, 1'b0, 6'h3f, 6'h15, 6'h2a}, 1'b0, '0},
      // start while busy on the step that runs out of channels
      '{'{32'h0000_0095, 1'b1, 6'h3f, 6'h00, 6'h00}, 1'b0, '0},
      '{'{32'h0000_0095, 1'b0, 6'h00, 6'h3f, 6'h3f}, 1'b0, '0}
   };

   // fire step then detect step for one item; updates the model state
   function automatic channel_report_type fire_and_detect(fire_item_type it);
      channel_report_type rep;
      logic [TIME_W-1:0]  elapsed;
      status_code_type    code;
      logic               found;
      int                 ch;
      if (it.fire_start)
         fire_armed = 1'b1;
      elapsed = it.time_now - last_fire_time;     // modulo 2^32
      if (fire_armed && elapsed >= action_gap_q) begin
         last_fire_time = it.time_now;
         found = 1'b0;
         // lowest masked channel at or after the current step
         for (ch = int'(next_chan); ch < NUM_CHANNELS; ch++) begin
            if (!found && it.channel_mask[ch]) begin
               drive_state[ch] = 1'b1;
               fired_state[ch] = 1'b1;
               next_chan = 3'(ch + 1);
               found = 1'b1;
            end
         end
         if (found) begin
            fire_actions++;
         end else begin
            // mask exhausted: sequence over
            drive_state = '0;
            fire_armed = 1'b0;
            next_chan = '0;
            seq_complete++;
         end
      end
      rep.channel_status = '0;
      for (ch = 0; ch < NUM_CHANNELS; ch++) begin
         if (it.ctl_sense[ch] || fired_state[ch])
            code = STATUS_FIRED;
         else if (it.det_sense[ch])
            code = STATUS_CONNECT;
         else
            code = STATUS_NO_CON;
         rep.channel_status[2*ch +: 2] = code;
      end
      rep.drive_enable = drive_state;
      rep.fire_busy = fire_armed;
      rep.fired_mask = fired_state;
      return rep;
   endfunction

   // random item shaped around the model state so that actions really happen
   function automatic fire_item_type pick_fire_item(logic [TIME_W-1:0] prev_time);
      fire_item_type it;
      int            pick;
      pick = $urandom_range(0, 9);
      if (pick <= 4)
         it.time_now = last_fire_time + action_gap_q + TIME_W'($urandom_range(0, 2));
      else if (pick <= 6)
         it.time_now = last_fire_time + action_gap_q - 32'd1;   // just short
      else if (pick == 7)
         it.time_now = prev_time;
      else if (pick == 8)
         it.time_now = $urandom;
      else
         it.time_now = prev_time + TIME_W'($urandom_range(0, 100));
      // mostly start when idle, now and then a stray start mid-sequence
      if (!fire_armed)
         it.fire_start = ($urandom_range(0, 3) == 0);
      else
         it.fire_start = ($urandom_range(0, 15) == 0);
      pick = $urandom_range(0, 9);
      if (pick == 0)
         it.channel_mask = '0;
      else if (pick == 1)
         it.channel_mask = '1;
      else
         it.channel_mask = FIELD_W'($urandom);
      // control pins kept sparse half the time so detect codes show up
      if ($urandom_range(0, 1) == 0)
         it.ctl_sense = FIELD_W'($urandom & $urandom);
      else
         it.ctl_sense = FIELD_W'($urandom);
      it.det_sense = FIELD_W'($urandom);
      return it;
   endfunction

   // one req transfer with burst/gap idling; prediction taken at acceptance
   task automatic send_item(fire_item_type it, logic typed, channel_report_type want);
      int                 gap;
      channel_report_type rep;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end else begin
         gap = 0;
      end
      burst_left--;
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {5'b0, it.det_sense, it.ctl_sense, it.channel_mask,
                     it.fire_start, it.time_now};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      // transfer accepted on this edge
      rep = fire_and_detect(it);
      pending_reports.push_back(typed ? want : rep);
      items_sent++;
   endtask

   // stop offering and wait out every owed report plus the pipeline
   task automatic drain_reports();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   task automatic write_action_gap(logic [TIME_W-1:0] value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      action_gap_q = value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      settings_used++;
   endtask

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      err_count++;
      $display("mismatch: %s on report %0d: got %0h, expected %0h",
               what, report_count, got, want);
   endtask

   // ------------------------------------------------------------------
   // main stimulus
   // ------------------------------------------------------------------
   initial begin
      logic [TIME_W-1:0] delay_plan [NUM_SETTINGS];
      logic [TIME_W-1:0] prev_time;
      fire_item_type     it;
      reset       = 1'b1;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      // model at reset
      action_gap_q   = ACTION_GAP_RESET;
      last_fire_time = '0;
      next_chan      = '0;
      fire_armed     = 1'b0;
      drive_state    = '0;
      fired_state    = '0;
      // zero delay, one, the maximum and half range, then a few ordinary settings
      delay_plan[0] = 32'd0;
      delay_plan[1] = 32'd1;
      delay_plan[2] = 32'hffff_ffff;
      delay_plan[3] = 32'h8000_0000;
      delay_plan[4] = TIME_W'($urandom_range(2, 300));
      delay_plan[5] = $urandom;
      delay_plan[6] = ACTION_GAP_RESET;
      delay_plan[7] = 32'd7;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table at the reset delay
      for (int r = 0; r < NUM_ROWS; r++)
         send_item(directed_rows[r].item, directed_rows[r].typed, directed_rows[r].want);
      prev_time = directed_rows[NUM_ROWS-1].item.time_now;

      // random phases, one per delay setting; register written only when idle
      for (int s = 0; s < NUM_SETTINGS; s++) begin
         drain_reports();
         write_action_gap(delay_plan[s]);
         for (int n = 0; n < ITEMS_PER_RUN; n++) begin
            // rsp side stalls for a long stretch once, req keeps coming
            if (s == 1 && n == 40)
               long_hold_req = 1'b1;
            it = pick_fire_item(prev_time);
            prev_time = it.time_now;
            send_item(it, 1'b0, '0);
         end
      end

      drain_reports();
      $display("run covered %0d items over %0d action gap settings",
               items_sent, settings_used);
      $display("model saw %0d channel firings and %0d completed sequences",
               fire_actions, seq_complete);
      if (err_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // ------------------------------------------------------------------
   // rsp side: stall pattern of its own, plus one long hold-off
   // ------------------------------------------------------------------
   initial begin
      int mode;
      int mode_left;
      rsp_tready = 1'b0;
      mode = 0;
      mode_left = 0;
      forever begin
         @(negedge clock);
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD - 1) @(negedge clock);
         end else begin
            if (mode_left == 0) begin
               mode = $urandom_range(0, 2);
               mode_left = $urandom_range(4, 60);
            end
            mode_left--;
            case (mode)
               0: begin
                  rsp_tready <= 1'b1;                  // streaming, no stalls
               end
               1: begin
                  rsp_tready <= 1'($urandom_range(0, 1));
               end
               default: begin
                  rsp_tready <= (mode_left % 4 == 0);  // one in four
               end
            endcase
         end
      end
   end

   // ------------------------------------------------------------------
   // rsp checker: each transfer against the oldest owed report
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      channel_report_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         report_count++;
         if (pending_reports.size() == 0) begin
            report_mismatch("unexpected rsp transfer", rsp_tdata, '0);
         end else begin
            want = pending_reports.pop_front();
            if (rsp_tdata[5:0] !== want.drive_enable)
               report_mismatch("drive_enable", 32'(rsp_tdata[5:0]), 32'(want.drive_enable));
            if (rsp_tdata[17:6] !== want.channel_status)
               report_mismatch("channel_status", 32'(rsp_tdata[17:6]),
                               32'(want.channel_status));
            if (rsp_tdata[18] !== want.fire_busy)
               report_mismatch("fire_busy", 32'(rsp_tdata[18]), 32'(want.fire_busy));
            if (rsp_tdata[24:19] !== want.fired_mask)
               report_mismatch("fired_mask", 32'(rsp_tdata[24:19]), 32'(want.fired_mask));
            if (rsp_tdata[31:25] !== '0)
               report_mismatch("zero fill", 32'(rsp_tdata[31:25]), '0);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d reports still owed",
                  cycle_count, pending_reports.size());
         $display("FAILED: results differ");
         $finish;
      end
   end

endmodule
